FILE: rtl/json_string_escaper_defines.svh
// ----------------------------------------------------------------------------
// json_string_escaper_defines.svh
// Assertion macros for the escaper's checker module.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define JSE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, off while reset is asserted.
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, constants and escape tables for the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  localparam int BYTE_W          = 8;
  localparam int CAP_W           = 16;
  localparam int POS_W           = 16;
  localparam int TOTAL_W         = 24;
  localparam int LEN_W           = 3;
  localparam int LENGTH_BITS_DEF = 24;

  localparam logic [CAP_W-1:0]   CAP_RESET = 16'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_N       = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_R       = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T       = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U       = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

  localparam logic [LEN_W-1:0] LEN_PLAIN   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_PAIR    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_UNICODE = 3'd6;

  // Index of each byte in the \u00XX form
  localparam logic [LEN_W-1:0] IDX_LEAD  = 3'd0;
  localparam logic [LEN_W-1:0] IDX_TAG   = 3'd1;
  localparam logic [LEN_W-1:0] IDX_ZERO0 = 3'd2;
  localparam logic [LEN_W-1:0] IDX_ZERO1 = 3'd3;
  localparam logic [LEN_W-1:0] IDX_HI    = 3'd4;
  localparam logic [LEN_W-1:0] IDX_LO    = 3'd5;

  // One decoded transaction, handed from the counters to the emitter
  typedef struct packed {
    logic [BYTE_W-1:0]  ch;        // source byte
    logic [LEN_W-1:0]   len;       // bytes to emit
    logic               store;     // sequence lands in the buffer
    logic [POS_W-1:0]   pos;       // first offset, or terminator offset
    logic               is_end;    // terminator transaction
    logic [TOTAL_W-1:0] total;     // saturated length for the terminator
  } item_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_A + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] esc_len(input logic [BYTE_W-1:0] ch);
    logic [LEN_W-1:0] r;
    case (ch)
      CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB: r = LEN_PAIR;
      default: begin
        r = (ch < CTRL_LIMIT) ? LEN_UNICODE : LEN_PLAIN;
      end
    endcase
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] esc_byte(input logic [BYTE_W-1:0] ch,
                                                input logic [LEN_W-1:0]  idx);
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] r;
    case (ch)
      CH_LF:   second = CH_N;
      CH_CR:   second = CH_R;
      CH_TAB:  second = CH_T;
      default: second = ch;
    endcase
    if (esc_len(ch) == LEN_PLAIN) begin
      r = ch;
    end else if (esc_len(ch) == LEN_PAIR) begin
      r = (idx == IDX_LEAD) ? CH_BSLASH : second;
    end else begin
      case (idx)
        IDX_LEAD:  r = CH_BSLASH;
        IDX_TAG:   r = CH_U;
        IDX_ZERO0: r = CH_ZERO;
        IDX_ZERO1: r = CH_ZERO;
        IDX_HI:    r = hex_digit(ch[7:4]);
        IDX_LO:    r = hex_digit(ch[3:0]);
        default:   r = CH_NUL;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Path: an accepted transaction enters the sequence register; the emitter
//   sends one result byte per cycle into the output register unless stalled.
// Throughput: one transaction per cycle for pass-through bytes and end
//   markers if unstalled; an L-byte escape (2 or 6) keeps the emitter busy.
// Reset (rst_n, synchronous, active low): counts clear, capacity goes to
//   256, both pipeline registers empty. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper #(
  parameter int LENGTH_BITS = jse_pkg::LENGTH_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration: buffer capacity in bytes, terminator slot included
  input  wire                              cfg_wr_en,
  input  wire  [jse_pkg::CAP_W-1:0]        cfg_wr_data,
  // source stream
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [jse_pkg::BYTE_W-1:0]       in_source_byte,
  input  wire                              in_end_of_string,
  // escaped stream
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [jse_pkg::BYTE_W-1:0]       out_byte,
  output logic [jse_pkg::POS_W-1:0]        out_position,
  output logic                             out_store_enable,
  output logic                             out_last_of_run,
  output logic [jse_pkg::TOTAL_W-1:0]      out_total_length
);
  import jse_pkg::*;

  // Widths wide enough to compare the logical count with 16-bit and 24-bit
  // quantities without losing bits.
  localparam int CMP_W = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;
  localparam int TOT_W = (LENGTH_BITS > TOTAL_W) ? LENGTH_BITS : TOTAL_W;

  logic [CAP_W-1:0]       cap_r;
  logic [LENGTH_BITS-1:0] logical_count_r;
  logic [LENGTH_BITS-1:0] logical_count_nxt;
  logic [CAP_W-1:0]       stored_count_r;
  logic [CAP_W-1:0]       stored_count_nxt;

  logic                   accept;
  logic                   can_load;
  logic [LEN_W-1:0]       seq_len;
  logic                   in_sync;
  logic [CAP_W:0]         stored_sum;
  logic                   fits;
  logic                   store;
  logic [LENGTH_BITS:0]   logical_sum;
  logic [TOT_W-1:0]       logical_ext;
  logic [CMP_W-1:0]       logical_cmp;
  logic [POS_W-1:0]       term_pos;
  logic [TOTAL_W-1:0]     term_total;
  item_t                  item;

  // A new transaction enters whenever the emitter is empty or is sending the
  // final byte of the current sequence this cycle.
  assign in_ready = can_load;
  assign accept   = in_valid && can_load;

  // Classify the byte and decide, against the counts as they stand now,
  // whether its whole sequence goes into the buffer.
  assign seq_len     = esc_len(in_source_byte);
  assign logical_cmp = CMP_W'(logical_count_r);
  assign in_sync     = (logical_cmp == CMP_W'(stored_count_r));
  assign stored_sum  = {1'b0, stored_count_r} + (CAP_W + 1)'(seq_len);
  assign fits        = (stored_sum < {1'b0, cap_r});
  assign store       = in_sync && fits;

  // Terminator goes to the first free slot, or the last slot if the buffer
  // filled up; a zero-capacity buffer takes nothing.
  always_comb begin
    if (cap_r == '0) begin
      term_pos = '0;
    end else if (stored_count_r < cap_r) begin
      term_pos = stored_count_r;
    end else begin
      term_pos = cap_r - CAP_W'(1);
    end
  end

  // Clamp the length to the 24-bit result field.
  assign logical_ext = TOT_W'(logical_count_r);
  assign term_total  = (logical_ext > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                        : logical_ext[TOTAL_W-1:0];

  always_comb begin
    item.ch     = in_source_byte;
    item.len    = in_end_of_string ? LEN_PLAIN : seq_len;
    item.store  = in_end_of_string ? (cap_r != '0) : store;
    item.pos    = in_end_of_string ? term_pos : logical_cmp[POS_W-1:0];
    item.is_end = in_end_of_string;
    item.total  = term_total;
  end

  // Counts advance at acceptance (logical saturating); end marker clears them.
  assign logical_sum = {1'b0, logical_count_r} + (LENGTH_BITS + 1)'(seq_len);

  always_comb begin
    logical_count_nxt = logical_count_r;
    stored_count_nxt  = stored_count_r;
    if (in_end_of_string) begin
      logical_count_nxt = '0;
      stored_count_nxt  = '0;
    end else begin
      logical_count_nxt = logical_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}}
                                                   : logical_sum[LENGTH_BITS-1:0];
      if (store) begin
        stored_count_nxt = stored_sum[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logical_count_r <= '0;
      stored_count_r  <= '0;
    end else if (accept) begin
      logical_count_r <= logical_count_nxt;
      stored_count_r  <= stored_count_nxt;
    end
  end

  // Capacity register; user writes it only while the block is idle, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Sequence register plus output register: hold the decoded transaction,
  // drop one byte per cycle into the result stage unless out_ready stalls.
  jse_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .item             (item),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_position     (out_position),
    .out_store_enable (out_store_enable),
    .out_last_of_run  (out_last_of_run),
    .out_total_length (out_total_length)
  );

endmodule

`default_nettype wire

FILE: rtl/jse_emitter.sv
// ----------------------------------------------------------------------------
// jse_emitter
// Holds one decoded transaction and sends its bytes, one per cycle, into
// the output register, unless a full output register waits on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_emitter (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              load,
  input  jse_pkg::item_t                   item,
  output logic                             can_load,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [jse_pkg::BYTE_W-1:0]       out_byte,
  output logic [jse_pkg::POS_W-1:0]        out_position,
  output logic                             out_store_enable,
  output logic                             out_last_of_run,
  output logic [jse_pkg::TOTAL_W-1:0]      out_total_length
);
  import jse_pkg::*;

  item_t              item_r;
  logic               seq_valid_r;
  logic [LEN_W-1:0]   idx_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [POS_W-1:0]   pos_r;
  logic               store_r;
  logic               last_r;
  logic [TOTAL_W-1:0] total_r;

  logic               out_free;
  logic               emit;
  logic               is_last;
  logic [BYTE_W-1:0]  byte_nxt;
  logic [POS_W-1:0]   pos_nxt;
  logic [TOTAL_W-1:0] total_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = seq_valid_r && out_free;
  assign is_last   = (idx_r == item_r.len - LEN_PLAIN);
  assign can_load  = !seq_valid_r || (emit && is_last);

  assign byte_nxt  = item_r.is_end ? CH_NUL : esc_byte(item_r.ch, idx_r);
  assign pos_nxt   = item_r.is_end ? item_r.pos : item_r.pos + POS_W'(idx_r);
  assign total_nxt = item_r.is_end ? item_r.total : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      seq_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (emit && is_last) begin
      seq_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + LEN_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= byte_nxt;
      pos_r   <= pos_nxt;
      store_r <= item_r.store;
      last_r  <= is_last;
      total_r <= total_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_position     = pos_r;
  assign out_store_enable = store_r;
  assign out_last_of_run  = last_r;
  assign out_total_length = total_r;

endmodule

`default_nettype wire

FILE: rtl/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks on the escaper's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_escaper_defines.svh"

module jse_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [jse_pkg::BYTE_W-1:0]    out_byte,
  input wire [jse_pkg::POS_W-1:0]     out_position,
  input wire                          out_last_of_run,
  input wire [jse_pkg::TOTAL_W-1:0]   out_total_length
);
  import jse_pkg::*;

  // A stalled result holds.
  `JSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_position) && $stable(out_total_length))

  // A NUL byte is only ever the terminator, which closes its run.
  `JSE_ASSERT_IMPLIES(a_nul_is_last, clk, rst_n, out_valid && (out_byte == CH_NUL), out_last_of_run)

  // A length only rides on the terminator.
  `JSE_ASSERT_IMPLIES(a_total_on_term, clk, rst_n, out_valid && (out_total_length != '0), out_last_of_run && (out_byte == CH_NUL))

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

`default_nettype wire

FILE: tb/sv/json_string_escaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_tb
// Self-checking bench for the JSON string escaper. Strings of source bytes,
// each closed by an end marker, go in over a valid/ready channel. A
// scoreboard predicts every escaped byte and terminator, with its position,
// store flag and length, and checks the result stream in order. The buffer
// capacity is changed between phases, from zero up to its largest value.
// ----------------------------------------------------------------------------

import jse_pkg::*;

class escape_scoreboard;

  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic [POS_W-1:0]   position;
    logic               store;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } esc_byte_t;

  localparam longint unsigned COUNT_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

  esc_byte_t       expected_q[$];
  logic [CAP_W-1:0] capacity;
  longint unsigned  logical_len;
  logic [CAP_W-1:0] stored_len;
  int               errors;

  function new();
    capacity    = CAP_RESET;
    logical_len = 0;
    stored_len  = '0;
    errors      = 0;
  endfunction

  function void set_capacity(input logic [CAP_W-1:0] value);
    capacity = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + BYTE_W'(nib) : CH_A - 8'd10 + BYTE_W'(nib);
  endfunction

  // Expand one accepted source transaction into its escaped bytes.
  function void note_source(input logic [BYTE_W-1:0] ch, input logic eos);
    logic [BYTE_W-1:0] seq [6];
    int unsigned       len;
    bit                fits;
    esc_byte_t         e;
    if (eos) begin
      e.data     = CH_NUL;
      e.position = '0;
      e.store    = 1'b0;
      e.last     = 1'b1;
      e.total    = (logical_len > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(logical_len);
      // A zero-size buffer has no slot even for the terminator
      if (capacity != '0) begin
        e.position = (stored_len < capacity) ? stored_len : capacity - 16'd1;
        e.store    = 1'b1;
      end
      expected_q.push_back(e);
      logical_len = 0;
      stored_len  = '0;
      return;
    end
    seq[0] = CH_BSLASH;
    len    = 2;
    case (ch)
      CH_QUOTE, CH_BSLASH: seq[1] = ch;
      CH_LF:               seq[1] = CH_N;
      CH_CR:               seq[1] = CH_R;
      CH_TAB:              seq[1] = CH_T;
      default: begin
        if (ch < CTRL_LIMIT) begin
          seq[1] = CH_U;
          seq[2] = CH_ZERO;
          seq[3] = CH_ZERO;
          seq[4] = hex_char(ch[7:4]);
          seq[5] = hex_char(ch[3:0]);
          len    = 6;
        end else begin
          seq[0] = ch;
          len    = 1;
        end
      end
    endcase
    // Store only while nothing has been dropped and the whole run fits
    fits = (logical_len == 64'(stored_len)) &&
           (32'(stored_len) + len < 32'(capacity));
    for (int k = 0; k < int'(len); k++) begin
      e.data     = seq[k];
      e.position = POS_W'(logical_len + 64'(k));
      e.store    = fits;
      e.last     = (k == int'(len) - 1);
      e.total    = '0;
      expected_q.push_back(e);
    end
    if (fits) stored_len = stored_len + CAP_W'(len);
    logical_len = (logical_len + len > COUNT_MAX) ? COUNT_MAX : logical_len + len;
  endfunction

  task report(input string what, input longint got, input longint want);
    $display("ERROR: %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  task check_byte(input logic [BYTE_W-1:0] data, input logic [POS_W-1:0] position,
                  input logic store, input logic last, input logic [TOTAL_W-1:0] total);
    esc_byte_t e;
    if (expected_q.size() == 0) begin
      report("unexpected result, byte", data, 0);
      return;
    end
    e = expected_q.pop_front();
    if (data !== e.data)         report("out_byte", data, e.data);
    if (position !== e.position) report("out_position", position, e.position);
    if (store !== e.store)       report("out_store_enable", store, e.store);
    if (last !== e.last)         report("out_last_of_run", last, e.last);
    if (total !== e.total)       report("out_total_length", total, e.total);
  endtask

endclass

module json_string_escaper_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT    = 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_source_byte = '0;
  logic               in_end_of_string = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic [POS_W-1:0]   out_position;
  logic               out_store_enable;
  logic               out_last_of_run;
  logic [TOTAL_W-1:0] out_total_length;

  escape_scoreboard sb = new();
  bit no_idle = 1'b0;
  int items_sent = 0;
  int stall_cycles = 0;

  always #6 clk = ~clk;

  json_string_escaper u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_position     (out_position),
    .out_store_enable (out_store_enable),
    .out_last_of_run  (out_last_of_run),
    .out_total_length (out_total_length)
  );

  // Offer one source transaction and hold it until the block takes it.
  // Valid drops only inside an idle gap, so back-to-back transactions
  // never lower and raise it in the same step.
  task automatic send_item(input logic [BYTE_W-1:0] ch, input logic eos);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_source_byte   <= ch;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    sb.note_source(ch, eos);
    items_sent++;
  endtask

  // Write the capacity only once every expected byte has come out.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Pick a byte, weighted toward the escaped classes.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    logic [BYTE_W-1:0] specials [5];
    specials = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB};
    r = $urandom_range(99);
    if (r < 15) return specials[$urandom_range(4)];
    if (r < 32) return BYTE_W'($urandom_range(31));
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic send_string(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(pick_byte(), 1'b0);
    send_item(BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  // Result side: check every accepted result, then pick next ready.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_byte(out_byte, out_position, out_store_enable, out_last_of_run,
                      out_total_length);
      end
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if neither channel moves for too long. Results
  // nobody is waiting for do not count as progress.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready && sb.pending() != 0))
        stall_cycles = 0;
      else stall_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] caps [10];
    caps = '{16'd1, 16'd2, 16'd5, 16'd9, 16'd16, 16'hFFFF, 16'd0, 16'd3, 16'd256, 16'd12};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every escape class at the reset capacity
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'hFF, 1'b1);

    // Zero capacity: nothing stored, terminator at offset zero
    set_capacity(16'd0);
    send_item(8'h61, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h00, 1'b1);

    // One slot: only the terminator fits
    set_capacity(16'd1);
    send_item(8'h00, 1'b1);
    send_item(8'h78, 1'b0);
    send_item(8'h00, 1'b1);

    // Long escape dropped, later plain byte dropped as well
    set_capacity(16'd4);
    send_item(8'h61, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h00, 1'b1);

    // Pair fits exactly, next byte does not
    set_capacity(16'd3);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(8'h00, 1'b1);

    // Random strings over a sweep of capacities; two phases run with no gaps
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      no_idle = (p == 4 || p == 5);
      begin
        int phase_start;
        phase_start = items_sent;
        while (items_sent - phase_start < 10) send_string($urandom_range(10));
      end
    end
    no_idle = 1'b0;

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
